### design/mhsu_pkg.sv
// ----------------------------------------------------------------------------
// mhsu_pkg
// Shared types, sizes and helpers for the MinHash signature update block.
// ----------------------------------------------------------------------------
package mhsu_pkg;

	localparam int NUM_HASH    = 30;
	localparam int NUM_SETS    = 1024;
	localparam int TBL_DEPTH   = NUM_HASH * NUM_SETS;
	localparam int HASH_W      = $clog2(NUM_HASH);
	localparam int SET_W       = 10;
	localparam int ELEM_W      = 16;
	localparam int COEF_W      = 8;
	localparam int VAL_W       = 16;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);
	localparam int PROD_W      = COEF_W + ELEM_W;
	localparam int STEP_W      = $clog2(PROD_W);
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam logic [VAL_W-1:0] MODULUS_RST = 16'd4039;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	// one classified command on its way from front to back
	typedef struct packed {
		action_t                  op;
		logic                     err;
		logic [HASH_W-1:0]        hidx;
		logic [SET_W-1:0]         sidx;
		logic [ELEM_W-1:0]        elem;
		logic [COEF_W-1:0]        coef_a;
		logic signed [COEF_W-1:0] coef_b;
	} cmd_t;

	// one signature table word
	typedef struct packed {
		logic             empty;
		logic [VAL_W-1:0] val;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// table word address of hash h, set s
	function automatic logic [TBL_AW-1:0] tbl_addr(logic [HASH_W-1:0] h,
		logic [SET_W-1:0] s);
		tbl_addr = TBL_AW'(TBL_AW'(h) * TBL_AW'(NUM_SETS) + TBL_AW'(s));
	endfunction

endpackage

### design/mhsu_ram.sv
// ----------------------------------------------------------------------------
// mhsu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mhsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/mhsu_front.sv
// ----------------------------------------------------------------------------
// mhsu_front
// Takes input items, range checks them and queues commands for the back end.
// ----------------------------------------------------------------------------
module mhsu_front import mhsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [5:0]  hash_index,
	input  logic [9:0]  set_index,
	input  logic [15:0] element_index,
	input  logic [7:0]  coef_a,
	input  logic signed [7:0] coef_b,
	input  logic        cmd_pop,
	output logic        cmd_vld,
	output cmd_t        cmd
);

	cmd_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wptr_q, rptr_q;
	logic [FIFO_AW:0]     cnt_q;
	cmd_t                 cls;
	logic                 hash_bad, set_bad, do_push, do_pop;

	// classify the incoming item
	always_comb begin
		hash_bad   = hash_index >= 6'(NUM_HASH);
		set_bad    = {1'b0, set_index} >= 11'(NUM_SETS);
		cls.op     = action_t'(action);
		cls.hidx   = hash_index[HASH_W-1:0];
		cls.sidx   = set_index;
		cls.elem   = element_index;
		cls.coef_a = coef_a;
		cls.coef_b = coef_b;
		case (action_t'(action))
			ACT_LOAD:   cls.err = hash_bad;
			ACT_INSERT: cls.err = set_bad;
			ACT_READ:   cls.err = hash_bad | set_bad;
			default:    cls.err = 1'b0;
		endcase
	end

	assign full    = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign do_push = push & ~full;
	assign cmd_vld = cnt_q != '0;
	assign do_pop  = cmd_pop & cmd_vld;
	assign cmd     = fifo_q[rptr_q];

	// command queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop)  rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### design/mhsu_back.sv
// ----------------------------------------------------------------------------
// mhsu_back
// Executes commands: coefficient loads, hash updates through one shared
// multiply and bit-serial modulo unit, table reads and clearing passes.
// ----------------------------------------------------------------------------
module mhsu_back import mhsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [VAL_W-1:0] modulus,
	input  logic             cmd_vld,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	output logic             res_vld,
	output logic [VAL_W-1:0] signature,
	output logic             status,
	input  logic             pop
);

	typedef enum logic [6:0] {
		ST_CLR  = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_UPD  = 7'b0010000,
		ST_RD   = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                   state_q;
	cmd_t                     cur_q;
	logic [TBL_AW-1:0]        clr_q;
	logic [HASH_W-1:0]        k_q;
	logic [STEP_W-1:0]        step_q;
	logic [PROD_W-1:0]        mag_q;
	logic [VAL_W-1:0]         rem_q;
	logic [VAL_W-1:0]         sig_q;
	logic                     err_q;
	logic [COEF_W-1:0]        mult_q [NUM_HASH];
	logic [COEF_W-1:0]        off_q  [NUM_HASH];
	logic                     res_vld_q;
	logic [VAL_W-1:0]         res_sig_q;
	logic                     res_st_q;

	logic                     we, re;
	logic [TBL_AW-1:0]        waddr, raddr;
	entry_t                   wdata, rdata;
	logic [PROD_W-1:0]        prod;
	logic signed [PROD_W:0]   sum;
	logic [PROD_W-1:0]        mag;
	logic [VAL_W:0]           mod_ext, rem_sh, rem_nx;
	logic                     out_free;

	mhsu_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// hash arithmetic: product with signed offset, then one remainder bit a cycle
	always_comb begin
		prod    = PROD_W'(mult_q[k_q]) * PROD_W'(cur_q.elem);
		sum     = $signed({1'b0, prod}) + (PROD_W+1)'($signed(off_q[k_q]));
		mag     = sum[PROD_W] ? PROD_W'(-sum) : sum[PROD_W-1:0];
		mod_ext = {modulus == '0, modulus};
		rem_sh  = {rem_q, mag_q[PROD_W-1]};
		rem_nx  = (rem_sh >= mod_ext) ? rem_sh - mod_ext : rem_sh;
	end

	assign out_free = ~res_vld_q | pop;
	assign cmd_pop  = (state_q == ST_IDLE) & cmd_vld;

	// table port control
	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '{empty: 1'b1, val: '0};
		re    = 1'b0;
		raddr = tbl_addr(k_q, cur_q.sidx);
		case (state_q)
			ST_CLR: begin
				we = 1'b1;
			end
			ST_IDLE: begin
				re    = cmd_vld & (cmd.op == ACT_READ) & ~cmd.err;
				raddr = tbl_addr(cmd.hidx, cmd.sidx);
			end
			ST_MUL: begin
				re = 1'b1;
			end
			ST_UPD: begin
				waddr = tbl_addr(k_q, cur_q.sidx);
				wdata = '{empty: 1'b0, val: rem_q};
				we    = rdata.empty | (rem_q < rdata.val);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			k_q     <= '0;
			step_q  <= '0;
			for (int i = 0; i < NUM_HASH; i++) begin
				mult_q[i] <= '0;
				off_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TBL_AW'(TBL_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_vld) begin
						case (cmd.op)
							ACT_LOAD: begin
								if (!cmd.err) begin
									mult_q[cmd.hidx] <= cmd.coef_a;
									off_q[cmd.hidx]  <= cmd.coef_b;
								end
								state_q <= ST_OUT;
							end
							ACT_INSERT: begin
								k_q     <= '0;
								state_q <= cmd.err ? ST_OUT : ST_MUL;
							end
							ACT_READ: begin
								state_q <= cmd.err ? ST_OUT : ST_RD;
							end
							default: begin
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
						endcase
					end
				end
				ST_MUL: begin
					step_q  <= STEP_W'(PROD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) state_q <= ST_UPD;
				end
				ST_UPD: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q == HASH_W'(NUM_HASH - 1)) ? ST_OUT : ST_MUL;
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_vld) begin
			cur_q <= cmd;
			err_q <= cmd.err;
			sig_q <= '0;
		end
		if (state_q == ST_MUL) begin
			mag_q <= mag;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			mag_q <= {mag_q[PROD_W-2:0], 1'b0};
			rem_q <= rem_nx[VAL_W-1:0];
		end
		if (state_q == ST_RD) begin
			sig_q <= rdata.empty ? modulus : rdata.val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			res_vld_q <= 1'b1;
		end else if (pop) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			res_sig_q <= sig_q;
			res_st_q  <= err_q;
		end
	end

	assign res_vld   = res_vld_q;
	assign signature = res_sig_q;
	assign status    = res_st_q;

endmodule

### design/minhash_signature_update_top.sv
// ----------------------------------------------------------------------------
// minhash_signature_update_top
// MinHash signature table: per hash and per set minimum of |a*x+b| mod modulus.
//
//   channel   direction  handshake               payload
//   items     in         push / full             action, hash_index, set_index,
//                                                element_index, coef_a, coef_b
//   results   out        empty / pop             signature, status
//   config    in         modulus_we              modulus_wdata
//
// Loads and rejected items go from idle straight to the output state, reads
// pass a table read state first. An insert runs, for each of the 30 hashes,
// a multiply step, remainder steps of the shared modulo unit and an update step.
// Reset and every clear run a clearing pass over the 30720 table words,
// one word a cycle; items queue meanwhile (four entries).
// A waiting result stalls the back end only at its next result.
// ----------------------------------------------------------------------------
module minhash_signature_update_top import mhsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [5:0]  hash_index,
	input  logic [9:0]  set_index,
	input  logic [15:0] element_index,
	input  logic [7:0]  coef_a,
	input  logic signed [7:0] coef_b,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] signature,
	output logic        status,
	input  logic        modulus_we,
	input  logic [15:0] modulus_wdata
);

	logic             cmd_vld, cmd_pop, res_vld;
	cmd_t             cmd;
	logic [VAL_W-1:0] modulus_q;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
		end else if (modulus_we) begin
			modulus_q <= modulus_wdata;
		end
	end

	mhsu_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.action        (action),
		.hash_index    (hash_index),
		.set_index     (set_index),
		.element_index (element_index),
		.coef_a        (coef_a),
		.coef_b        (coef_b),
		.cmd_pop       (cmd_pop),
		.cmd_vld       (cmd_vld),
		.cmd           (cmd)
	);

	mhsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.modulus   (modulus_q),
		.cmd_vld   (cmd_vld),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_vld   (res_vld),
		.signature (signature),
		.status    (status),
		.pop       (pop)
	);

	assign empty = ~res_vld;

endmodule

### design/mhsu_checker.sv
// ----------------------------------------------------------------------------
// mhsu_checker
// Port level checks on the MinHash block, bound to the top level.
// ----------------------------------------------------------------------------
module mhsu_checker import mhsu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic [1:0]  action,
	input logic        empty,
	input logic        pop,
	input logic [15:0] signature,
	input logic        status
);

	logic [7:0] pend_q;
	logic       acc_res, pop_tr;

	// items owed a result, less results transferred
	assign acc_res = push & ~full & (action_t'(action) != ACT_CLEAR);
	assign pop_tr  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {7'd0, acc_res} - {7'd0, pop_tr};
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 8'd0)
		else $error("result shown with no item owing one");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> signature == 16'd0)
		else $error("error result with non-zero signature");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(signature) && $stable(status)))
		else $error("waiting result changed");

endmodule

bind minhash_signature_update_top mhsu_checker u_mhsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.action    (action),
	.empty     (empty),
	.pop       (pop),
	.signature (signature),
	.status    (status)
);
